FILE: hdl/ica_pkg.sv
// Package for the complementary-filter attitude block: constants, register
// indexes, the sequencer phase type and the CORDIC arctangent table.
// No dependencies.
package ica_pkg;

	// Default and largest supported number of CORDIC iterations.
	localparam int CORDIC_STEPS_DEF = 16;
	localparam int ATAN_LEN = 24;

	// Configuration port address width and register indexes.
	localparam int ADDR_W = 4;
	localparam logic [1:0] REG_BLEND  = 2'd0;
	localparam logic [1:0] REG_BIAS_X = 2'd1;
	localparam logic [1:0] REG_BIAS_Y = 2'd2;
	localparam logic [1:0] REG_BIAS_Z = 2'd3;

	// Blend weight: one in Q1.16 and the reset value.
	localparam logic [16:0] ALPHA_ONE   = 17'h10000;
	localparam logic [16:0] ALPHA_RESET = 17'd655;

	// Angle constants with 30 fraction bits.
	localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
	localparam logic signed [35:0] TWO_PI_Q30  = 36'sd6746518852;
	localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
	localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;

	// Radians to degrees, tangent limit and angle state limits.
	localparam logic [23:0]        RAD2DEG_Q16 = 24'd3754936;
	localparam logic signed [23:0] TAN_MAX     = 24'sd4194304;
	localparam logic signed [19:0] ANGLE_MAX   = 20'sd524287;
	localparam logic signed [19:0] ANGLE_MIN   = -20'sd524288;

	// Lengths of the serial units, counted from zero.
	localparam logic [5:0] MUL_LAST  = 6'd25;
	localparam logic [5:0] MUL2_LAST = 6'd50;
	localparam logic [5:0] DIV_LAST  = 6'd24;
	localparam logic [5:0] SQRT_LAST = 6'd25;

	// Phases of the sequencer, in execution order.
	typedef enum logic [4:0] {
		ST_IDLE,
		ST_SC_ROLL,
		ST_SC_PITCH,
		ST_TAN,
		ST_M_STN,
		ST_M_TGY,
		ST_M_CTN,
		ST_M_TGZ,
		ST_M_CGY,
		ST_M_SGZ,
		ST_M_DTR,
		ST_M_DTP,
		ST_SQ_ROLL,
		ST_RT_ROLL,
		ST_AT_ROLL,
		ST_SQ_PITCH,
		ST_RT_PITCH,
		ST_AT_PITCH,
		ST_BL_ROLL,
		ST_BL_PITCH,
		ST_DEG_ROLL,
		ST_DEG_PITCH,
		ST_DONE
	} phase_t;

	// Successor of a working phase once its unit has finished.
	function automatic phase_t next_phase(input phase_t ph);
		phase_t nx;
		unique case (ph)
			ST_SC_ROLL:   nx = ST_SC_PITCH;
			ST_SC_PITCH:  nx = ST_TAN;
			ST_TAN:       nx = ST_M_STN;
			ST_M_STN:     nx = ST_M_TGY;
			ST_M_TGY:     nx = ST_M_CTN;
			ST_M_CTN:     nx = ST_M_TGZ;
			ST_M_TGZ:     nx = ST_M_CGY;
			ST_M_CGY:     nx = ST_M_SGZ;
			ST_M_SGZ:     nx = ST_M_DTR;
			ST_M_DTR:     nx = ST_M_DTP;
			ST_M_DTP:     nx = ST_SQ_ROLL;
			ST_SQ_ROLL:   nx = ST_RT_ROLL;
			ST_RT_ROLL:   nx = ST_AT_ROLL;
			ST_AT_ROLL:   nx = ST_SQ_PITCH;
			ST_SQ_PITCH:  nx = ST_RT_PITCH;
			ST_RT_PITCH:  nx = ST_AT_PITCH;
			ST_AT_PITCH:  nx = ST_BL_ROLL;
			ST_BL_ROLL:   nx = ST_BL_PITCH;
			ST_BL_PITCH:  nx = ST_DEG_ROLL;
			ST_DEG_ROLL:  nx = ST_DEG_PITCH;
			ST_DEG_PITCH: nx = ST_DONE;
			default:      nx = ST_IDLE;
		endcase
		return nx;
	endfunction

	// atan(2^-i) with 30 fraction bits.
	function automatic logic [29:0] atan_q30(input logic [4:0] idx);
		logic [29:0] v;
		case (idx)
			5'd0:  v = 30'd843314857;
			5'd1:  v = 30'd497837829;
			5'd2:  v = 30'd263043837;
			5'd3:  v = 30'd133525159;
			5'd4:  v = 30'd67021687;
			5'd5:  v = 30'd33543516;
			5'd6:  v = 30'd16775851;
			5'd7:  v = 30'd8388437;
			5'd8:  v = 30'd4194283;
			5'd9:  v = 30'd2097149;
			5'd10: v = 30'd1048576;
			5'd11: v = 30'd524288;
			5'd12: v = 30'd262144;
			5'd13: v = 30'd131072;
			5'd14: v = 30'd65536;
			5'd15: v = 30'd32768;
			5'd16: v = 30'd16384;
			5'd17: v = 30'd8192;
			5'd18: v = 30'd4096;
			5'd19: v = 30'd2048;
			5'd20: v = 30'd1024;
			5'd21: v = 30'd512;
			5'd22: v = 30'd256;
			5'd23: v = 30'd128;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

FILE: hdl/imu_complementary_attitude.sv
// Complementary-filter roll and pitch estimator with an APB register port.
// Depends on ica_pkg.
//
// One item (gyro rates, accelerometer axes, time step) gives one result item
// (roll and pitch in degrees). The work runs through serial units: a shared
// iterative CORDIC (one rotation per cycle), a shared bit-serial multiplier (one
// multiplier bit per cycle), a restoring divider for the tangent (one quotient
// bit per cycle) and a square-root unit (one result bit per cycle).
// The eighteen serial products take most of the time of an item. One item is
// worked on at a time; in_ready is high while the sequencer is idle, and a
// finished result waits in the output register so the next item can be taken
// meanwhile. The user must write configuration only while the block is idle;
// the block itself does not enforce this. The angle state clears on reset; no
// clearing pass is needed.
module imu_complementary_attitude #(
	parameter int CORDIC_STEPS = ica_pkg::CORDIC_STEPS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [ica_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [23:0]         rate_x,
	input  logic signed [23:0]         rate_y,
	input  logic signed [23:0]         rate_z,
	input  logic signed [15:0]         accel_x,
	input  logic signed [15:0]         accel_y,
	input  logic signed [15:0]         accel_z,
	input  logic [15:0]                step_time,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [23:0]         roll_deg,
	output logic signed [23:0]         pitch_deg
);
	import ica_pkg::*;

	localparam int NSTEP = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
	localparam logic [5:0] CORDIC_LAST = 6'(NSTEP + 1);

	// Sequencer and configuration.
	phase_t state_q, state_d;
	logic [5:0] cnt_q, last_cnt;
	logic step_done, out_free, out_load;
	logic [16:0] alpha_cfg_q;
	logic signed [23:0] bias_x_q, bias_y_q, bias_z_q;
	logic signed [19:0] roll_est_q, pitch_est_q;
	logic out_valid_q;
	logic [23:0] roll_out_q, pitch_out_q, deg_r_q;

	// Captured item.
	logic signed [24:0] gy_q, gz_q;
	logic signed [15:0] ax_q, ay_q, az_q;
	logic [15:0] dt_q;
	logic [16:0] alpha_q;

	// Intermediate values.
	logic signed [17:0] s16_q, c16_q, pa_q, ta_q;
	logic signed [33:0] st_q, ct_q, pd_q;
	logic signed [23:0] tn_q, t1_q;
	logic signed [26:0] td_q;
	logic signed [35:0] pp_q, tp_q;
	logic [24:0] h_q;

	// Serial multiplier.
	logic signed [63:0] acc_q, mc_q, r16, r18, sat_v;
	logic [23:0] mb_q;
	logic signed [39:0] mul_a;
	logic [23:0] mul_b;
	logic mul_dbl, mul_on, mul_second, mul_load, mul_last;

	// CORDIC.
	logic signed [33:0] cx_q, cy_q, cz_q, cdx, cdy, ctab, cx_fix;
	logic neg_q, zero_q, crot, cpos;
	logic [4:0] ci;
	logic signed [35:0] ang36, z0, zw, zf;
	logic zneg;
	logic signed [16:0] vnum;
	logic signed [34:0] cx14, cy14, cz14;

	// Divider for the tangent.
	logic [33:0] abs_st, abs_ct, dd_q;
	logic [35:0] dr_q, dr2;
	logic [22:0] dn_q;
	logic dneg_q, dfix_q, dge;

	// Square root.
	logic [47:0] sn_q, sr_q, sb_q, sq_t;
	logic sge;

	logic cfg_wr;
	logic [16:0] alpha_lim;

	// Configuration port.
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_comb begin
		unique case (paddr[3:2])
			REG_BLEND:  prdata = 32'(alpha_cfg_q);
			REG_BIAS_X: prdata = 32'(unsigned'(bias_x_q));
			REG_BIAS_Y: prdata = 32'(unsigned'(bias_y_q));
			REG_BIAS_Z: prdata = 32'(unsigned'(bias_z_q));
			default:    prdata = '0;
		endcase
	end

	// Length of each phase, in cycles less one.
	always_comb begin
		case (state_q) inside
			ST_SC_ROLL, ST_SC_PITCH, ST_AT_ROLL, ST_AT_PITCH: last_cnt = CORDIC_LAST;
			ST_TAN:                                          last_cnt = DIV_LAST;
			ST_RT_ROLL, ST_RT_PITCH:                         last_cnt = SQRT_LAST;
			ST_SQ_ROLL, ST_SQ_PITCH, ST_BL_ROLL, ST_BL_PITCH: last_cnt = MUL2_LAST;
			ST_IDLE, ST_DONE:                                last_cnt = '0;
			default:                                         last_cnt = MUL_LAST;
		endcase
	end

	assign step_done = (cnt_q == last_cnt);
	assign out_free  = !out_valid_q || out_ready;

	// Next phase.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_SC_ROLL;
			ST_DONE: if (out_free) state_d = ST_IDLE;
			default: if (step_done) state_d = next_phase(state_q);
		endcase
	end

	// Handshake outputs of the sequencer.
	always_comb begin
		in_ready = (state_q == ST_IDLE);
		out_load = (state_q == ST_DONE) && out_free;
	end

	assign out_valid = out_valid_q;
	assign roll_deg  = signed'(roll_out_q);
	assign pitch_deg = signed'(pitch_out_q);
	assign alpha_lim = (alpha_cfg_q > ALPHA_ONE) ? ALPHA_ONE : alpha_cfg_q;

	// Multiplier operand selection.
	always_comb begin
		mul_on = 1'b1;
		mul_dbl = 1'b0;
		mul_second = (cnt_q >= MUL_LAST);
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_M_STN: begin mul_a = 40'(tn_q); mul_b = 24'(s16_q); end
			ST_M_TGY: begin mul_a = 40'(gy_q); mul_b = t1_q; end
			ST_M_CTN: begin mul_a = 40'(tn_q); mul_b = 24'(c16_q); end
			ST_M_TGZ: begin mul_a = 40'(gz_q); mul_b = t1_q; end
			ST_M_CGY: begin mul_a = 40'(gy_q); mul_b = 24'(c16_q); end
			ST_M_SGZ: begin mul_a = 40'(gz_q); mul_b = 24'(s16_q); end
			ST_M_DTR: begin mul_a = 40'(pd_q); mul_b = 24'(dt_q); end
			ST_M_DTP: begin mul_a = 40'(td_q); mul_b = 24'(dt_q); end
			ST_SQ_ROLL: begin
				mul_dbl = 1'b1;
				mul_a = mul_second ? 40'(az_q) : 40'(ax_q);
				mul_b = mul_second ? 24'(az_q) : 24'(ax_q);
			end
			ST_SQ_PITCH: begin
				mul_dbl = 1'b1;
				mul_a = mul_second ? 40'(az_q) : 40'(ay_q);
				mul_b = mul_second ? 24'(az_q) : 24'(ay_q);
			end
			ST_BL_ROLL: begin
				mul_dbl = 1'b1;
				mul_a = mul_second ? 40'(pa_q) : 40'(pp_q);
				mul_b = mul_second ? 24'(alpha_q) : 24'(17'(ALPHA_ONE - alpha_q));
			end
			ST_BL_PITCH: begin
				mul_dbl = 1'b1;
				mul_a = mul_second ? 40'(ta_q) : 40'(tp_q);
				mul_b = mul_second ? 24'(alpha_q) : 24'(17'(ALPHA_ONE - alpha_q));
			end
			ST_DEG_ROLL:  begin mul_a = 40'(roll_est_q); mul_b = RAD2DEG_Q16; end
			ST_DEG_PITCH: begin mul_a = 40'(pitch_est_q); mul_b = RAD2DEG_Q16; end
			default: mul_on = 1'b0;
		endcase
		mul_load = (cnt_q == '0) || (mul_dbl && cnt_q == MUL_LAST);
		mul_last = (cnt_q == MUL_LAST - 6'd1) || (cnt_q == MUL2_LAST - 6'd1);
	end

	// Rounded views of the product.
	assign r16 = (acc_q + 64'sd32768) >>> 16;
	assign r18 = (acc_q + 64'sd131072) >>> 18;
	assign sat_v = (r16 > 64'(ANGLE_MAX)) ? 64'(ANGLE_MAX) :
		(r16 < 64'(ANGLE_MIN)) ? 64'(ANGLE_MIN) : r16;

	// CORDIC step and initial values.
	always_comb begin
		crot = (state_q == ST_SC_ROLL) || (state_q == ST_SC_PITCH);
		ci = 5'(cnt_q - 6'd1);
		cdx = cy_q >>> ci;
		cdy = cx_q >>> ci;
		ctab = 34'(atan_q30(ci));
		cpos = crot ? !cz_q[33] : cy_q[33];
		ang36 = (state_q == ST_SC_ROLL) ? 36'(roll_est_q) : 36'(pitch_est_q);
		z0 = ang36 <<< 14;
		if (z0 > PI_Q30) zw = z0 - TWO_PI_Q30;
		else if (z0 < -PI_Q30) zw = z0 + TWO_PI_Q30;
		else zw = z0;
		zneg = 1'b1;
		if (zw > HALF_PI_Q30) zf = PI_Q30 - zw;
		else if (zw < -HALF_PI_Q30) zf = -PI_Q30 - zw;
		else begin
			zf = zw;
			zneg = 1'b0;
		end
		vnum = (state_q == ST_AT_ROLL) ? 17'(ay_q) : -17'(ax_q);
		cx_fix = neg_q ? -cx_q : cx_q;
		cx14 = (35'(cx_fix) + 35'sd8192) >>> 14;
		cy14 = (35'(cy_q) + 35'sd8192) >>> 14;
		cz14 = (35'(cz_q) + 35'sd8192) >>> 14;
	end

	// Divider and square-root steps.
	always_comb begin
		abs_st = st_q[33] ? 34'(-st_q) : 34'(st_q);
		abs_ct = ct_q[33] ? 34'(-ct_q) : 34'(ct_q);
		dr2 = {dr_q[34:0], dn_q[22]};
		dge = (dr2 >= 36'(dd_q));
		sq_t = sr_q + sb_q;
		sge = (sn_q >= sq_t);
	end

	// Control state, configuration and angle state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
			alpha_cfg_q <= ALPHA_RESET;
			bias_x_q <= '0;
			bias_y_q <= '0;
			bias_z_q <= '0;
			roll_est_q <= '0;
			pitch_est_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_d != state_q) cnt_q <= '0;
			else if (state_q != ST_IDLE && state_q != ST_DONE) cnt_q <= cnt_q + 6'd1;
			if (out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			if (cfg_wr) begin
				unique case (paddr[3:2])
					REG_BLEND:  alpha_cfg_q <= pwdata[16:0];
					REG_BIAS_X: bias_x_q <= signed'(pwdata[23:0]);
					REG_BIAS_Y: bias_y_q <= signed'(pwdata[23:0]);
					REG_BIAS_Z: bias_z_q <= signed'(pwdata[23:0]);
					default: ;
				endcase
			end
			if (step_done && state_q == ST_BL_ROLL) roll_est_q <= sat_v[19:0];
			if (step_done && state_q == ST_BL_PITCH) pitch_est_q <= sat_v[19:0];
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		// Capture of an accepted item.
		if (in_valid && in_ready) begin
			gy_q <= 25'(rate_y) - 25'(bias_y_q);
			gz_q <= 25'(rate_z) - 25'(bias_z_q);
			pd_q <= 34'(25'(rate_x) - 25'(bias_x_q));
			ax_q <= accel_x;
			ay_q <= accel_y;
			az_q <= accel_z;
			dt_q <= step_time;
			alpha_q <= alpha_lim;
		end

		// Bit-serial multiply, one multiplier bit per cycle.
		if (mul_on && !step_done) begin
			if (mul_load) begin
				mc_q <= 64'(mul_a);
				mb_q <= mul_b;
				if (cnt_q == '0) acc_q <= '0;
			end else begin
				if (mb_q[0]) acc_q <= mul_last ? acc_q - mc_q : acc_q + mc_q;
				mc_q <= mc_q <<< 1;
				mb_q <= mb_q >> 1;
			end
		end

		// Shared CORDIC, rotation for sine and cosine, vectoring for atan2.
		if (state_q == ST_SC_ROLL || state_q == ST_SC_PITCH ||
				state_q == ST_AT_ROLL || state_q == ST_AT_PITCH) begin
			if (cnt_q == '0) begin
				if (crot) begin
					cx_q <= GAIN_Q30;
					cy_q <= '0;
					cz_q <= 34'(zf);
					neg_q <= zneg;
				end else begin
					cx_q <= 34'(h_q);
					cy_q <= 34'(vnum) <<< 8;
					cz_q <= '0;
					zero_q <= (h_q == '0) && (vnum == '0);
				end
			end else if (!step_done) begin
				if (cpos) begin
					cx_q <= cx_q - cdx;
					cy_q <= cy_q + cdy;
					cz_q <= cz_q - ctab;
				end else begin
					cx_q <= cx_q + cdx;
					cy_q <= cy_q - cdy;
					cz_q <= cz_q + ctab;
				end
			end
		end

		// Tangent as a restoring division, one quotient bit per cycle.
		if (state_q == ST_TAN) begin
			if (cnt_q == '0) begin
				dd_q <= abs_ct;
				dneg_q <= st_q[33] ^ ct_q[33];
				dr_q <= 36'(abs_st >> 7);
				dn_q <= {abs_st[6:0], 16'b0};
				if (st_q == '0) begin
					tn_q <= '0;
					dfix_q <= 1'b1;
				end else if ({6'b0, abs_st} >= {abs_ct, 6'b0}) begin
					tn_q <= (st_q[33] != ct_q[33]) ? -TAN_MAX : TAN_MAX;
					dfix_q <= 1'b1;
				end else begin
					dfix_q <= 1'b0;
				end
			end else if (!step_done) begin
				dr_q <= dge ? dr2 - 36'(dd_q) : dr2;
				dn_q <= {dn_q[21:0], dge};
			end else if (!dfix_q) begin
				tn_q <= dneg_q ? -24'(dn_q) : 24'(dn_q);
			end
		end

		// Square root, one result bit per cycle.
		if (state_q == ST_RT_ROLL || state_q == ST_RT_PITCH) begin
			if (cnt_q == '0) begin
				sn_q <= {acc_q[31:0], 16'b0};
				sr_q <= '0;
				sb_q <= 48'h1 << 46;
			end else if (!step_done) begin
				if (sge) begin
					sn_q <= sn_q - sq_t;
					sr_q <= (sr_q >> 1) + sb_q;
				end else begin
					sr_q <= sr_q >> 1;
				end
				sb_q <= sb_q >> 2;
			end else begin
				h_q <= sr_q[24:0];
			end
		end

		// Results of each phase.
		if (step_done) begin
			case (state_q)
				ST_SC_ROLL: begin
					s16_q <= cy14[17:0];
					c16_q <= cx14[17:0];
				end
				ST_SC_PITCH: begin
					st_q <= cy_q;
					ct_q <= cx_fix;
				end
				ST_M_STN, ST_M_CTN: t1_q <= r16[23:0];
				ST_M_TGY, ST_M_TGZ: pd_q <= pd_q + signed'(r16[33:0]);
				ST_M_CGY: td_q <= r16[26:0];
				ST_M_SGZ: td_q <= td_q - signed'(r16[26:0]);
				ST_M_DTR: pp_q <= 36'(roll_est_q) + signed'(r16[35:0]);
				ST_M_DTP: tp_q <= 36'(pitch_est_q) + signed'(r16[35:0]);
				ST_AT_ROLL: pa_q <= zero_q ? '0 : cz14[17:0];
				ST_AT_PITCH: ta_q <= zero_q ? '0 : cz14[17:0];
				ST_DEG_ROLL: deg_r_q <= r18[23:0];
				default: ;
			endcase
		end

		// Output register.
		if (out_load) begin
			roll_out_q <= deg_r_q;
			pitch_out_q <= r18[23:0];
		end
	end

	// The sequencer takes no new item in the cycle after one is accepted.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item accepted while the sequencer was busy");

	// The phase counter never runs past the end of its phase.
	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= last_cnt)
		else $error("phase counter overran");

	// The tangent never exceeds its saturation limit when it is used.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_M_STN |-> (tn_q <= TAN_MAX && tn_q >= -TAN_MAX))
		else $error("tangent out of range");

	// A result appears only from the final phase.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_DONE)
		else $error("result raised outside the final phase");

	// In vectoring mode the CORDIC x stays non-negative.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_AT_ROLL || state_q == ST_AT_PITCH) && cnt_q != '0 |-> !cx_q[33])
		else $error("CORDIC vectoring x went negative");

endmodule
